/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the frame deframer.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, masked while reset is applied.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/ufd_pkg.sv */
// Package for the frame deframer: phase and result codes, register indexes,
// the CRC-16/CCITT-FALSE byte update function and shared types. No dependencies.
package ufd_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_RESET    = 8'hA5;
    localparam logic [7:0] TIMEOUT_RESET = 8'd50;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } phase_t;

    typedef struct packed {
        logic clear;
        logic update;
    } crc_ctrl_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/uart_frame_deframer_crc16_top.sv */
// Top level of the length-prefixed frame deframer with CRC-16/CCITT-FALSE.
// Depends on ufd_pkg, ufd_crc16 and assert_macros.svh.
//
// The block takes one transfer per clock cycle while not stalled: each
// received byte or millisecond tick updates the frame state in the cycle it
// is accepted, and any result is loaded into an output register and shown on
// the m_ channel the next cycle. Each item needs only the single registered
// state update, including the unrolled byte-wide CRC step. Input is stalled
// only while the output register holds a result not yet taken. Frames are
// sync, command, length (little endian), payload, CRC (little endian).
// The user must write configuration (cfg_wr_en, cfg_index, cfg_wr_data) only
// while idle, which the block does not enforce; unknown indexes are ignored.
`include "assert_macros.svh"

module uart_frame_deframer_crc16_top import ufd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [7:0]            m_command,
    output logic [7:0]            m_payload_byte,
    output logic [7:0]            m_payload_index,
    output logic [8:0]            m_frame_length
);

    localparam int          CNT_W   = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [7:0]       sync_reg;
    logic [7:0]       timeout_reg;

    phase_t           phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic [7:0]       idle_reg, idle_next;

    logic             m_valid_reg, m_valid_next;
    kind_t            kind_reg;
    logic [7:0]       m_cmd_reg;
    logic [7:0]       m_byte_reg;
    logic [7:0]       m_idx_reg;
    logic [8:0]       m_len_reg;

    logic             in_fire;
    logic             emit;
    kind_t            kind_res;
    logic [7:0]       byte_res;
    logic [7:0]       idx_res;
    logic [8:0]       len_sat;
    logic [7:0]       idle_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      cnt_wide;
    crc_ctrl_t        crc_ctrl;
    logic [15:0]      crc_value;

    assign s_ready  = ~m_valid_reg | m_ready;
    assign in_fire  = s_valid & s_ready;
    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cnt_wide = 16'(cnt_reg);
    assign len_sat  = (|len_next[15:9]) ? 9'h1FF : len_next[8:0];

    ufd_crc16 u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data    (s_rx_byte),
        .crc     (crc_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SYNC_BYTE) begin
                sync_reg <= cfg_wr_data;
            end else if (cfg_index == CFG_TIMEOUT_MS) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        crc_low_next    = crc_low_reg;
        idle_next       = idle_reg;
        crc_ctrl.clear  = 1'b0;
        crc_ctrl.update = 1'b0;
        emit            = 1'b0;
        kind_res        = KIND_DATA;
        byte_res        = 8'h00;
        idx_res         = 8'h00;
        if (in_fire) begin
            if (s_op == OP_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    if (idle_inc >= timeout_reg) begin
                        phase_next = PH_HUNT;
                        idle_next  = 8'h00;
                        emit       = 1'b1;
                        kind_res   = KIND_ABORT;
                    end else begin
                        idle_next = idle_inc;
                    end
                end
            end else begin
                idle_next = 8'h00;
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (s_rx_byte == sync_reg) begin
                            cmd_next       = 8'h00;
                            len_next       = 16'h0000;
                            cnt_next       = '0;
                            crc_low_next   = 8'h00;
                            crc_ctrl.clear = 1'b1;
                            phase_next     = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        cmd_next        = s_rx_byte;
                        crc_ctrl.update = 1'b1;
                        phase_next      = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        len_next        = {8'h00, s_rx_byte};
                        crc_ctrl.update = 1'b1;
                        phase_next      = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        len_next        = {s_rx_byte, len_reg[7:0]};
                        crc_ctrl.update = 1'b1;
                        if (len_next > MAX_LEN) begin
                            phase_next = PH_HUNT;
                            emit       = 1'b1;
                            kind_res   = KIND_ABORT;
                        end else begin
                            cnt_next   = '0;
                            phase_next = (len_next == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        crc_ctrl.update = 1'b1;
                        cnt_next        = cnt_inc;
                        if (16'(cnt_inc) >= len_reg) begin
                            phase_next = PH_CRC_LO;
                        end
                        emit     = 1'b1;
                        kind_res = KIND_DATA;
                        byte_res = s_rx_byte;
                        idx_res  = cnt_wide[7:0];
                    end
                    PH_CRC_LO: begin
                        crc_low_next = s_rx_byte;
                        phase_next   = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        kind_res   = ({s_rx_byte, crc_low_reg} == crc_value) ? KIND_GOOD
                                                                           : KIND_BAD;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            cmd_reg     <= 8'h00;
            len_reg     <= 16'h0000;
            cnt_reg     <= '0;
            crc_low_reg <= 8'h00;
            idle_reg    <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            crc_low_reg <= crc_low_next;
            idle_reg    <= idle_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && emit) begin
            kind_reg   <= kind_res;
            m_cmd_reg  <= cmd_next;
            m_byte_reg <= byte_res;
            m_idx_reg  <= idx_res;
            m_len_reg  <= len_sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_command       = m_cmd_reg;
    assign m_payload_byte  = m_byte_reg;
    assign m_payload_index = m_idx_reg;
    assign m_frame_length  = m_len_reg;

    `ASSERT_CLKD(a_count_in_range, (phase_reg == PH_PAYLOAD) |-> (16'(cnt_reg) < len_reg), "payload count reached the declared length inside the payload")
    `ASSERT_ALWAYS(a_hunt_idle_clear, (phase_reg == PH_HUNT) |-> (idle_reg == 8'h00), "idle tick count not cleared while hunting")
    `ASSERT_CLKD(a_verdict_emitted, (in_fire && s_op == OP_BYTE && phase_reg == PH_CRC_HI) |=> (m_valid_reg && phase_reg == PH_HUNT), "CRC high byte did not produce a verdict and return to hunting")

endmodule

/* rtl/ufd_crc16.sv */
// Running CRC-16/CCITT-FALSE register with a one-byte-per-cycle update.
// Depends on ufd_pkg for the update function and the control struct.
module ufd_crc16 import ufd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_ctrl_t   ctrl,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctrl.clear) begin
            crc_next = CRC_INIT;
        end else if (ctrl.update) begin
            crc_next = crc16_byte(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

/* dv/ufd_deframe_checker.sv */
// Checker for the frame deframer: watches the input, result and register ports,
// predicts every result and compares it field by field with what the block sends.
// Depends on ufd_pkg; also holds the small package that the testbench top shares.
package ufd_tb_pkg;
    import ufd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [8:0] frame_length;
    } deframe_event_t;

    function automatic logic [15:0] crc16_ccitt_update(input logic [15:0] crc_in,
                                                       input logic [7:0]  data);
        logic [15:0] crc;
        logic        feedback;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            feedback = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction
endpackage

module ufd_deframe_checker import ufd_pkg::*; import ufd_tb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_op,
    input  logic [7:0]            s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_kind,
    input  logic [7:0]            m_command,
    input  logic [7:0]            m_payload_byte,
    input  logic [7:0]            m_payload_index,
    input  logic [8:0]            m_frame_length,
    output int                    mismatch_count,
    output int                    events_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]     sync_value    = SYNC_RESET;
    logic [7:0]     tick_limit    = TIMEOUT_RESET;
    phase_t         cur_phase     = PH_HUNT;
    logic [7:0]     cmd_seen      = '0;
    logic [15:0]    declared_len  = '0;
    logic [8:0]     payload_count = '0;
    logic [15:0]    crc_acc       = CRC_INIT;
    logic [7:0]     crc_first     = '0;
    logic [7:0]     idle_ticks    = '0;
    deframe_event_t frame_events_due[$];
    int             mismatches    = 0;

    function automatic deframe_event_t pack_event(input kind_t kind,
                                                  input logic [7:0] data,
                                                  input logic [7:0] position);
        deframe_event_t ev;
        ev.kind          = kind;
        ev.command       = cmd_seen;
        ev.payload_byte  = data;
        ev.payload_index = position;
        ev.frame_length  = (declared_len > 16'd511) ? 9'h1FF : declared_len[8:0];
        return ev;
    endfunction

    function automatic bit deframe_step(input logic op, input logic [7:0] b,
                                        output deframe_event_t ev);
        bit produced;
        produced = 1'b0;
        ev = '0;
        if (op == OP_TICK) begin
            if (cur_phase != PH_HUNT) begin
                if (idle_ticks != 8'hFF) begin
                    idle_ticks = idle_ticks + 8'd1;
                end
                if (idle_ticks >= tick_limit) begin
                    cur_phase  = PH_HUNT;
                    idle_ticks = '0;
                    ev = pack_event(KIND_ABORT, '0, '0);
                    produced = 1'b1;
                end
            end
        end else begin
            idle_ticks = '0;
            case (cur_phase)
                PH_HUNT: begin
                    if (b == sync_value) begin
                        cmd_seen      = '0;
                        declared_len  = '0;
                        payload_count = '0;
                        crc_acc       = CRC_INIT;
                        crc_first     = '0;
                        cur_phase     = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_seen  = b;
                    crc_acc   = crc16_ccitt_update(crc_acc, b);
                    cur_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    declared_len = {8'h00, b};
                    crc_acc      = crc16_ccitt_update(crc_acc, b);
                    cur_phase    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    declared_len[15:8] = b;
                    crc_acc = crc16_ccitt_update(crc_acc, b);
                    if (declared_len > MAX_PAYLOAD_DEF) begin
                        cur_phase = PH_HUNT;
                        ev = pack_event(KIND_ABORT, '0, '0);
                        produced = 1'b1;
                    end else begin
                        payload_count = '0;
                        cur_phase = (declared_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_acc = crc16_ccitt_update(crc_acc, b);
                    ev = pack_event(KIND_DATA, b, payload_count[7:0]);
                    produced = 1'b1;
                    payload_count = payload_count + 9'd1;
                    if (payload_count >= declared_len) begin
                        cur_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    crc_first = b;
                    cur_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    cur_phase = PH_HUNT;
                    if ({b, crc_first} == crc_acc) begin
                        ev = pack_event(KIND_GOOD, '0, '0);
                    end else begin
                        ev = pack_event(KIND_BAD, '0, '0);
                    end
                    produced = 1'b1;
                end
                default: begin
                    cur_phase = PH_HUNT;
                end
            endcase
        end
        return produced;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        deframe_event_t ev;
        deframe_event_t want;
        if (!aresetn) begin
            sync_value    = SYNC_RESET;
            tick_limit    = TIMEOUT_RESET;
            cur_phase     = PH_HUNT;
            cmd_seen      = '0;
            declared_len  = '0;
            payload_count = '0;
            crc_acc       = CRC_INIT;
            crc_first     = '0;
            idle_ticks    = '0;
            frame_events_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SYNC_BYTE) begin
                    sync_value = cfg_wr_data;
                end else if (cfg_index == CFG_TIMEOUT_MS) begin
                    tick_limit = cfg_wr_data;
                end
            end
            if (m_valid && m_ready) begin
                if (frame_events_due.size() == 0) begin
                    $error("unexpected result transfer: kind %0d, command %0d",
                           m_kind, m_command);
                    mismatches++;
                end else begin
                    want = frame_events_due.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("command", want.command, m_command);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("payload_index", want.payload_index, m_payload_index);
                    check_field("frame_length", want.frame_length, m_frame_length);
                end
            end
            if (s_valid && s_ready) begin
                if (deframe_step(s_op, s_rx_byte, ev)) begin
                    frame_events_due.push_back(ev);
                end
            end
        end
        events_due     <= frame_events_due.size();
        mismatch_count <= mismatches;
    end

endmodule

/* dv/uart_frame_deframer_crc16_top_tb.sv */
// Testbench top for the frame deframer: clock, reset, register setup and frame stimulus,
// with random idling on both channels. Depends on ufd_pkg, ufd_tb_pkg and the checker
// module in ufd_deframe_checker.sv, which predicts and compares every result.
module uart_frame_deframer_crc16_top_tb;
    import ufd_pkg::*;
    import ufd_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 70;
    localparam int RAND_PHASES  = 5;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_SYNC_BYTE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_op        = OP_BYTE;
    logic [7:0]            s_rx_byte   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_kind;
    logic [7:0]            m_command;
    logic [7:0]            m_payload_byte;
    logic [7:0]            m_payload_index;
    logic [8:0]            m_frame_length;

    int         mismatch_count;
    int         events_due;
    int         cycle_count  = 0;
    int         frame_items  = 0;
    bit         steady       = 1'b0;
    bit         stretch_gaps = 1'b0;
    logic [7:0] sync_cfg     = SYNC_RESET;
    logic [7:0] timeout_cfg  = TIMEOUT_RESET;

    uart_frame_deframer_crc16_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_command       (m_command),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_length  (m_frame_length)
    );

    ufd_deframe_checker deframe_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_command       (m_command),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_length  (m_frame_length),
        .mismatch_count  (mismatch_count),
        .events_due      (events_due)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_item(input logic op, input logic [7:0] data, input bit counted);
        while (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (counted) begin
            frame_items++;
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (events_due != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] sync_v, input logic [7:0] limit_v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SYNC_BYTE;
        cfg_wr_data <= sync_v;
        @(posedge aclk);
        cfg_index   <= CFG_TIMEOUT_MS;
        cfg_wr_data <= limit_v;
        @(posedge aclk);
        cfg_index   <= ($urandom_range(1) == 0) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI;
        cfg_wr_data <= 8'($urandom);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sync_cfg    = sync_v;
        timeout_cfg = limit_v;
    endtask

    // Ticks ahead of a byte stay below the timeout, so the frame survives them.
    task automatic frame_byte(input logic [7:0] b);
        int room;
        int gap;
        room = (timeout_cfg > 1) ? timeout_cfg - 1 : 0;
        if (stretch_gaps) begin
            gap = room;
        end else if (room > 0 && $urandom_range(99) < 15) begin
            gap = $urandom_range((room < 4) ? room : 4, 1);
        end else begin
            gap = 0;
        end
        repeat (gap) push_item(OP_TICK, 8'($urandom), 1'b1);
        push_item(OP_BYTE, b, 1'b1);
    endtask

    // A cut shorter than the frame stops sending there and lets the timeout expire.
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input logic [15:0] crc_flip, input int cut);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          last;
        crc = CRC_INIT;
        frame_bytes = {sync_cfg, cmd, len[7:0], len[15:8]};
        for (int i = 1; i < 4; i++) begin
            crc = crc16_ccitt_update(crc, frame_bytes[i]);
        end
        if (len <= MAX_PAYLOAD_DEF) begin
            for (int i = 0; i < len; i++) begin
                b = ($urandom_range(9) == 0) ? sync_cfg : 8'($urandom);
                frame_bytes.push_back(b);
                crc = crc16_ccitt_update(crc, b);
            end
            crc = crc ^ crc_flip;
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end
        last = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
        push_item(OP_BYTE, frame_bytes[0], 1'b1);
        for (int i = 1; i < last; i++) begin
            frame_byte(frame_bytes[i]);
        end
        if (last < frame_bytes.size()) begin
            repeat ((timeout_cfg == 0) ? 1 : timeout_cfg) push_item(OP_TICK, 8'($urandom), 1'b0);
        end
    endtask

    task automatic noise_burst();
        logic [7:0] b;
        repeat ($urandom_range(4, 1)) begin
            b = 8'($urandom);
            if (b == sync_cfg) begin
                b = ~b;
            end
            push_item(OP_BYTE, b, 1'b0);
        end
    endtask

    task automatic random_frame();
        int          pick;
        logic [15:0] len;
        logic [15:0] flip;
        logic [7:0]  cmd;
        pick = $urandom_range(99);
        cmd  = 8'($urandom);
        len  = ($urandom_range(99) < 3) ? 16'($urandom_range(256, 13))
                                         : 16'($urandom_range(12, 0));
        if (pick < 62) begin
            send_frame(cmd, len, 16'h0000, 0);
        end else if (pick < 74) begin
            flip = ($urandom_range(1) == 0) ? 16'(1 << $urandom_range(15))
                                            : 16'($urandom_range(16'hFFFF, 1));
            send_frame(cmd, len, flip, 0);
        end else if (pick < 82) begin
            len = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, 257));
            send_frame(cmd, len, 16'h0000, 0);
        end else if (pick < 92) begin
            send_frame(cmd, len, 16'h0000, $urandom_range(len + 5, 1));
        end else begin
            noise_burst();
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) push_item(OP_TICK, 8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int goal;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(8'h00, 16'd0, 16'h0000, 0);
        send_frame(8'hFF, 16'd1, 16'h0000, 0);
        send_frame(sync_cfg, 16'd3, 16'h0000, 0);
        send_frame(8'h3C, 16'd4, 16'h0001, 0);
        send_frame(8'hC3, 16'd2, 16'h8000, 0);
        send_frame(8'h5A, 16'd256, 16'h0000, 0);
        send_frame(8'h11, 16'd257, 16'h0000, 0);
        send_frame(8'h22, 16'h01FF, 16'h0000, 0);
        send_frame(8'h33, 16'h0200, 16'h0000, 0);
        send_frame(8'h44, 16'hFFFF, 16'h0000, 0);
        repeat (3) push_item(OP_TICK, 8'hFF, 1'b0);
        noise_burst();
        for (int cut = 1; cut <= 8; cut++) begin
            send_frame(8'h81, 16'd3, 16'h0000, cut);
        end
        stretch_gaps = 1'b1;
        send_frame(8'h77, 16'd2, 16'h0000, 0);
        stretch_gaps = 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            steady <= (ph == 3);
            case (ph)
                0: program_regs(8'h00, 8'd1);
                1: program_regs(8'hFF, 8'd255);
                2: program_regs(8'($urandom), 8'd0);
                3: program_regs(8'($urandom), 8'($urandom_range(20, 2)));
                default: program_regs(8'($urandom), 8'($urandom_range(255, 1)));
            endcase
            goal = frame_items + PHASE_ITEMS;
            while (frame_items < goal) begin
                random_frame();
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ufd_pkg.sv
rtl/ufd_crc16.sv
rtl/uart_frame_deframer_crc16_top.sv
dv/ufd_deframe_checker.sv
dv/uart_frame_deframer_crc16_top_tb.sv
